### hw/rtl/rosm_pkg.sv
`timescale 1ns / 1ps

package rosm_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND_A = 2'd0,
    OP_APPEND_B = 2'd1,
    OP_MERGE    = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage

### hw/rtl/rosm_ram.sv
`timescale 1ns / 1ps

module rosm_ram import rosm_pkg::*; #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  data_t             wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output data_t             rdata
);

  data_t mem [DEPTH];
  data_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold the last word read until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/rosm_seq.sv
`timescale 1ns / 1ps

module rosm_seq import rosm_pkg::*; #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = 5,
  parameter int unsigned CNT_W  = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  op_t               in_op,
  output logic              a_we,
  output logic              a_re,
  output logic [ADDR_W-1:0] a_waddr,
  output logic [ADDR_W-1:0] a_raddr,
  input  data_t             a_rdata,
  output logic              b_we,
  output logic              b_re,
  output logic [ADDR_W-1:0] b_waddr,
  output logic [ADDR_W-1:0] b_raddr,
  input  data_t             b_rdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  output data_t             out_value,
  output logic              out_from_b,
  output logic              out_last
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0] cnt_b_r, cnt_b_nxt;
  logic [CNT_W-1:0] ia_r, ia_nxt;
  logic [CNT_W-1:0] ib_r, ib_nxt;
  logic             out_valid_r, out_valid_nxt;
  data_t            out_value_r, out_value_nxt;
  logic             out_from_b_r, out_from_b_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_fire;
  logic             out_free;
  logic             step;
  logic             take_a;
  logic             last_one;
  logic [CNT_W:0]   remain;
  logic [CNT_W-1:0] cnt_a_m1, cnt_b_m1, ia_m1, ib_m1, ia_m2, ib_m2;

  always_comb begin
    in_tready = (state_r == S_IDLE);
    in_fire   = in_tvalid && in_tready;
    out_free  = !out_valid_r || out_tready;
    step      = (state_r == S_RUN) && out_free;

    cnt_a_m1 = cnt_a_r - CNT_W'(1);
    cnt_b_m1 = cnt_b_r - CNT_W'(1);
    ia_m1    = ia_r - CNT_W'(1);
    ib_m1    = ib_r - CNT_W'(1);
    ia_m2    = ia_r - CNT_W'(2);
    ib_m2    = ib_r - CNT_W'(2);

    take_a   = (ib_r == '0) || ((ia_r != '0) && (a_rdata > b_rdata));
    remain   = {1'b0, ia_r} + {1'b0, ib_r};
    last_one = (remain == (CNT_W+1)'(1));

    a_we    = in_fire && (in_op == OP_APPEND_A) && (cnt_a_r != CNT_W'(DEPTH));
    b_we    = in_fire && (in_op == OP_APPEND_B) && (cnt_b_r != CNT_W'(DEPTH));
    a_waddr = cnt_a_r[ADDR_W-1:0];
    b_waddr = cnt_b_r[ADDR_W-1:0];

    a_re    = 1'b0;
    b_re    = 1'b0;
    a_raddr = cnt_a_m1[ADDR_W-1:0];
    b_raddr = cnt_b_m1[ADDR_W-1:0];

    state_nxt      = state_r;
    cnt_a_nxt      = cnt_a_r;
    cnt_b_nxt      = cnt_b_r;
    ia_nxt         = ia_r;
    ib_nxt         = ib_r;
    out_value_nxt  = out_value_r;
    out_from_b_nxt = out_from_b_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && !out_tready;

    unique case (state_r)
      S_IDLE: begin
        if (a_we) begin
          cnt_a_nxt = cnt_a_r + CNT_W'(1);
        end
        if (b_we) begin
          cnt_b_nxt = cnt_b_r + CNT_W'(1);
        end
        if (in_fire && (in_op == OP_MERGE) && ((cnt_a_r != '0) || (cnt_b_r != '0))) begin
          a_re      = 1'b1;
          b_re      = 1'b1;
          ia_nxt    = cnt_a_r;
          ib_nxt    = cnt_b_r;
          cnt_a_nxt = '0;
          cnt_b_nxt = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (step) begin
          out_valid_nxt  = 1'b1;
          out_from_b_nxt = !take_a;
          out_last_nxt   = last_one;
          if (take_a) begin
            out_value_nxt = a_rdata;
            ia_nxt        = ia_m1;
            a_re          = 1'b1;
            a_raddr       = ia_m2[ADDR_W-1:0];
          end else begin
            out_value_nxt = b_rdata;
            ib_nxt        = ib_m1;
            b_re          = 1'b1;
            b_raddr       = ib_m2[ADDR_W-1:0];
          end
          if (last_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ia_r        <= '0;
      ib_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      ia_r        <= ia_nxt;
      ib_r        <= ib_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_value_r  <= out_value_nxt;
    out_from_b_r <= out_from_b_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_value  = out_value_r;
  assign out_from_b = out_from_b_r;
  assign out_last   = out_last_r;

endmodule

### hw/rtl/reverse_order_sorted_merge_core.sv
`timescale 1ns / 1ps

// channel | bus         | tdata            | tuser     | tlast
// in      | in_t*       | [31:0] value     | [1:0] op  | -
// out     | out_t*      | [31:0] value_res | [0] from_b| last
//
// in_tready stays high while idle, so appends are accepted without waiting.
// A merge of N elements first reads both list tails from the two RAMs, then
// gives one result per unstalled cycle from the registered RAM read ports.
// in_tready is low for the whole merge; out_tready low stalls the merge.
// rst_n (synchronous) empties both lists; list RAM contents are not cleared.
module reverse_order_sorted_merge_core import rosm_pkg::*; #(
  parameter int unsigned DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [31:0] value
  input  logic [OP_W-1:0]   in_tuser,   // [1:0] op
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // [31:0] value_res
  output logic              out_tuser,  // [0] from_b
  output logic              out_tlast
);

  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  logic              a_we, a_re, b_we, b_re;
  logic [ADDR_W-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
  data_t             a_rdata, b_rdata;
  data_t             out_value;

  rosm_seq #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .CNT_W  (CNT_W)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (op_t'(in_tuser)),
    .a_we       (a_we),
    .a_re       (a_re),
    .a_waddr    (a_waddr),
    .a_raddr    (a_raddr),
    .a_rdata    (a_rdata),
    .b_we       (b_we),
    .b_re       (b_re),
    .b_waddr    (b_waddr),
    .b_raddr    (b_raddr),
    .b_rdata    (b_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (out_value),
    .out_from_b (out_tuser),
    .out_last   (out_tlast)
  );

  rosm_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (data_t'(in_tdata)),
    .re    (a_re),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  rosm_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (data_t'(in_tdata)),
    .re    (b_re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  assign out_tdata = out_value;

endmodule

### hw/rtl/rosm_chk.sv
`timescale 1ns / 1ps

module rosm_chk import rosm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [OP_W-1:0]   in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata,
  input logic              out_tuser,
  input logic              out_tlast
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_busy_mid_merge: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input open in the middle of a merge");

  a_result_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result outside a merge");

  a_append_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != OP_MERGE) && !out_tvalid |=> !out_tvalid)
    else $error("result without a merge");

endmodule

bind reverse_order_sorted_merge_core rosm_chk u_rosm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

### sim/reverse_order_sorted_merge_core_tb.sv
`timescale 1ns / 1ps

module reverse_order_sorted_merge_core_tb;
  import rosm_pkg::*;

  localparam int unsigned DEPTH       = 32;
  localparam int          ITEMS       = 370;
  localparam int          HOLD_CYCLES = 300;
  localparam int          STALL_LIMIT = 4000;
  localparam int          SETTLE      = 20;

  typedef struct {
    data_t value;
    logic  from_b;
    logic  last;
  } merged_elem_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata   = '0;
  logic [OP_W-1:0]   in_tuser   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic              out_tuser;
  logic              out_tlast;

  data_t        list_a[$];
  data_t        list_b[$];
  merged_elem_t merged_q[$];

  bit steady   = 1'b0;
  bit hold_req = 1'b0;
  int errors          = 0;
  int items_sent      = 0;
  int merges_done     = 0;
  int elems_checked   = 0;
  int idle_cycles     = 0;

  reverse_order_sorted_merge_core #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic void merge_lists();
    int           ia;
    int           ib;
    int           total;
    int           n;
    bit           take_a;
    merged_elem_t e;
    ia    = list_a.size();
    ib    = list_b.size();
    total = ia + ib;
    n     = 0;
    while (ia > 0 || ib > 0) begin
      if (ia > 0 && ib > 0) begin
        take_a = list_a[ia-1] > list_b[ib-1];
      end else begin
        take_a = (ia > 0);
      end
      if (take_a) begin
        e.value = list_a[ia-1];
        ia--;
      end else begin
        e.value = list_b[ib-1];
        ib--;
      end
      e.from_b = !take_a;
      e.last   = (n + 1 == total);
      merged_q.push_back(e);
      n++;
    end
    list_a.delete();
    list_b.delete();
  endfunction

  function automatic void apply_transaction(op_t op, data_t val);
    case (op)
      OP_APPEND_A: begin
        if (list_a.size() < DEPTH) list_a.push_back(val);
      end
      OP_APPEND_B: begin
        if (list_b.size() < DEPTH) list_b.push_back(val);
      end
      OP_MERGE: begin
        merge_lists();
        merges_done++;
      end
      default: ;
    endcase
  endfunction

  function automatic void report_mismatch(string what);
    if (errors < 10) $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) apply_transaction(op_t'(in_tuser), data_t'(in_tdata));
  end

  always @(posedge clk) begin
    merged_elem_t e;
    if (rst_n && out_tvalid && out_tready) begin
      elems_checked++;
      if (merged_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d from_b=%0b last=%0b",
                                  $signed(out_tdata), out_tuser, out_tlast));
      end else begin
        e = merged_q.pop_front();
        if (out_tdata !== e.value)
          report_mismatch($sformatf("value exp %0d got %0d", e.value, $signed(out_tdata)));
        if (out_tuser !== e.from_b)
          report_mismatch($sformatf("from_b exp %0b got %0b", e.from_b, out_tuser));
        if (out_tlast !== e.last)
          report_mismatch($sformatf("last exp %0b got %0b", e.last, out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        for (int i = 1; i < HOLD_CYCLES; i++) @(posedge clk);
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 23);
      end
    end
  end

  task automatic send_item(input op_t op, input data_t val);
    while (!steady && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    if (op != OP_NONE) items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (merged_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic data_t rand_value(input int kind);
    case (kind)
      0: return data_t'($urandom_range(8)) - 4;
      1: begin
        case ($urandom_range(3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic send_run(input int na, input int nb, input bit sorted, input int kind);
    data_t va[$];
    data_t vb[$];
    int    ia;
    int    ib;
    for (int i = 0; i < na; i++) va.push_back(rand_value(kind));
    for (int i = 0; i < nb; i++) vb.push_back(rand_value(kind));
    if (sorted) begin
      va.sort();
      vb.sort();
    end
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if (ib >= nb || (ia < na && $urandom_range(1) == 0)) begin
        send_item(OP_APPEND_A, va[ia]);
        ia++;
      end else begin
        send_item(OP_APPEND_B, vb[ib]);
        ib++;
      end
    end
    send_item(OP_MERGE, data_t'($urandom));
  endtask

  task automatic test_extremes_and_ties();
    send_item(OP_APPEND_A, 32'sh8000_0000);
    send_item(OP_APPEND_A, 0);
    send_item(OP_APPEND_A, 5);
    send_item(OP_APPEND_B, -1);
    send_item(OP_APPEND_B, 5);
    send_item(OP_APPEND_B, 32'sh7FFF_FFFF);
    send_item(OP_MERGE, 32'hFFFF_FFFF);
  endtask

  task automatic test_empty_and_unused_ops();
    send_item(OP_MERGE, 0);
    send_item(OP_NONE, 32'hFFFF_FFFF);
    send_item(OP_APPEND_B, 7);
    send_item(OP_NONE, 32'h1234_5678);
    send_item(OP_MERGE, 32'h5555_AAAA);
  endtask

  task automatic test_single_list();
    send_item(OP_APPEND_A, -3);
    send_item(OP_APPEND_A, 1);
    send_item(OP_APPEND_A, 9);
    send_item(OP_MERGE, 0);
  endtask

  task automatic test_unsorted_contents();
    send_item(OP_APPEND_A, 10);
    send_item(OP_APPEND_A, -10);
    send_item(OP_APPEND_B, 3);
    send_item(OP_APPEND_B, 3);
    send_item(OP_APPEND_B, -20);
    send_item(OP_MERGE, 0);
  endtask

  task automatic test_full_lists_under_backpressure();
    send_run(0, 0, 1'b1, 2);
    for (int i = 0; i < DEPTH + 2; i++) send_item(OP_APPEND_A, rand_value(2));
    for (int i = 0; i < DEPTH + 1; i++) send_item(OP_APPEND_B, rand_value(2));
    hold_req = 1'b1;
    send_item(OP_MERGE, 0);
    for (int i = 0; i < 6; i++) send_item(OP_APPEND_B, rand_value(0));
    send_item(OP_MERGE, 0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int limit);
    int sel;
    int na;
    int nb;
    int kind;
    while (items_sent < limit) begin
      sel  = $urandom_range(99);
      kind = $urandom_range(3);
      na   = ($urandom_range(11) == 0) ? $urandom_range(DEPTH + 2) : $urandom_range(6);
      nb   = ($urandom_range(11) == 0) ? $urandom_range(DEPTH + 2) : $urandom_range(6);
      if (sel < 80) begin
        send_run(na, nb, 1'b1, kind);
      end else if (sel < 90) begin
        send_run(na, nb, 1'b0, kind);
      end else if (sel < 95) begin
        send_item(OP_NONE, data_t'($urandom));
      end else begin
        send_item(OP_MERGE, data_t'($urandom));
      end
    end
  endtask

  task automatic test_steady_stream(input int limit);
    steady = 1'b1;
    test_random_traffic(limit);
    steady = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes_and_ties();
    test_empty_and_unused_ops();
    test_single_list();
    test_unsorted_contents();
    test_full_lists_under_backpressure();
    test_random_traffic(ITEMS / 2);
    test_steady_stream(ITEMS * 3 / 4);
    test_random_traffic(ITEMS);
    send_item(OP_MERGE, 0);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("coverage: %0d transactions sent, %0d merges, %0d merged elements checked",
             items_sent, merges_done, elems_checked);
    $display("  including full-list drops, empty merges, ties, unsorted lists and long stalls");
    if (errors == 0 && merged_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, merged_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
